// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Condition holds at every edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/bpq_pkg.sv =====
// Types, constants and codes of the bounded priority queue.
`default_nettype none
package bpq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_LIST   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] new_data;
    logic signed [31:0] new_priority;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] entry_data;
    logic               is_last;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic             load;
    logic [1:0]       status;
    logic             sel_entry;
    logic             last;
    logic [IDX_W-1:0] idx;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic             full;
    logic             empty;
    logic [CNT_W-1:0] count;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/bpq_store.sv =====
// Datapath: sorted shifting entry store, entry count and result register.
`default_nettype none
`include "assert_macros.svh"
module bpq_store
  import bpq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dp_cmd_t            cmd,
  input  wire logic signed [31:0] new_data,
  input  wire logic signed [31:0] new_priority,
  output dp_sts_t                 sts,
  output out_item_t               res
);

  logic signed [31:0] val_r [DEPTH];
  logic signed [31:0] pri_r [DEPTH];
  logic signed [31:0] val_nxt [DEPTH];
  logic signed [31:0] pri_nxt [DEPTH];
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DEPTH-1:0]   take;
  out_item_t          res_r, res_nxt;

  // A cell takes a shifted or new entry at or after the insert position.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      take[i] = (CNT_W'(i) == cnt_r) ||
                ((CNT_W'(i) < cnt_r) && (pri_r[i] > new_priority));
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      val_nxt[i] = val_r[i];
      pri_nxt[i] = pri_r[i];
    end
    cnt_nxt = cnt_r;
    if (cmd.ins) begin
      if (take[0]) begin
        val_nxt[0] = new_data;
        pri_nxt[0] = new_priority;
      end
      for (int i = 1; i < DEPTH; i++) begin
        if (take[i-1]) begin
          val_nxt[i] = val_r[i-1];
          pri_nxt[i] = pri_r[i-1];
        end else if (take[i]) begin
          val_nxt[i] = new_data;
          pri_nxt[i] = new_priority;
        end
      end
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.rem) begin
      // Advance every entry toward the head.
      for (int i = 0; i < DEPTH - 1; i++) begin
        val_nxt[i] = val_r[i+1];
        pri_nxt[i] = pri_r[i+1];
      end
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_comb begin
    res_nxt = res_r;
    if (cmd.load) begin
      res_nxt.status     = cmd.status;
      res_nxt.entry_data = cmd.sel_entry ? val_r[cmd.idx] : 32'sd0;
      res_nxt.is_last    = cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      val_r[i] <= val_nxt[i];
      pri_r[i] <= pri_nxt[i];
    end
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign sts.full  = (cnt_r == CNT_W'(DEPTH));
  assign sts.empty = (cnt_r == '0);
  assign sts.count = cnt_r;
  assign res       = res_r;

  `ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= CNT_W'(DEPTH))
  `ASSERT_IMPL(a_ins_not_full, clk, rst_n, cmd.ins, !sts.full && !cmd.rem)
  `ASSERT_NEXT(a_ins_count, clk, rst_n, cmd.ins, cnt_r == $past(cnt_r) + CNT_W'(1))
  `ASSERT_IMPL(a_rem_not_empty, clk, rst_n, cmd.rem, !sts.empty)

endmodule
`default_nettype wire

// ===== rtl/core/bpq_ctrl.sv =====
// Controller: handshake, command decode and list sequencing.
`default_nettype none
`include "assert_macros.svh"
module bpq_ctrl
  import bpq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] command,
  output logic            in_ready,
  input  wire logic       out_ready,
  output logic            out_valid,
  input  wire dp_sts_t    sts,
  output dp_cmd_t         cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LIST = 1'b1;

  logic             state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;
  logic             accept;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (command)
            CMD_INSERT: begin
              cmd.ins    = !sts.full;
              cmd.load   = 1'b1;
              cmd.status = sts.full ? ST_FULL : ST_OK;
              cmd.last   = 1'b1;
            end
            CMD_REMOVE: begin
              cmd.rem    = !sts.empty;
              cmd.load   = 1'b1;
              cmd.status = sts.empty ? ST_EMPTY : ST_OK;
              cmd.last   = 1'b1;
            end
            CMD_LIST: begin
              cmd.load = 1'b1;
              if (sts.empty) begin
                cmd.status = ST_EMPTY;
                cmd.last   = 1'b1;
              end else begin
                cmd.status    = ST_OK;
                cmd.sel_entry = 1'b1;
                cmd.idx       = '0;
                cmd.last      = (sts.count == CNT_W'(1));
                if (sts.count != CNT_W'(1)) begin
                  state_nxt = S_LIST;
                  idx_nxt   = IDX_W'(1);
                end
              end
            end
            default: begin
              // Drop the unused command without a result.
            end
          endcase
        end
      end
      S_LIST: begin
        if (out_free) begin
          cmd.load      = 1'b1;
          cmd.status    = ST_OK;
          cmd.sel_entry = 1'b1;
          cmd.idx       = idx_r;
          cmd.last      = (CNT_W'(idx_r) + CNT_W'(1) == sts.count);
          if (cmd.last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `ASSERT_IMPL(a_list_nonempty, clk, rst_n, state_r == S_LIST, !sts.empty && !cmd.ins && !cmd.rem)
  `ASSERT_IMPL(a_list_idx_range, clk, rst_n, state_r == S_LIST, CNT_W'(idx_r) < sts.count)
  `ASSERT_IMPL(a_load_slot_free, clk, rst_n, cmd.load, out_free)

endmodule
`default_nettype wire

// ===== rtl/core/bounded_priority_queue.sv =====
// Top level of the bounded priority queue: controller plus sorted-store datapath.
// Each command's first result is registered in the cycle after its transfer.
// While the single output register is free, insert and remove take one item per
// cycle, and a list, holding the input until its last entry is loaded, gives one
// result per cycle. Insert is one parallel compare-and-shift over all store cells.
// Reset (rst_n low, synchronous) empties the queue and clears the output valid.
`default_nettype none
module bounded_priority_queue
  import bpq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  bpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .command   (in_item.command),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  bpq_store u_store (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .new_data     (in_item.new_data),
    .new_priority (in_item.new_priority),
    .sts          (sts),
    .res          (out_item)
  );

endmodule
`default_nettype wire
